@@ hdl/bam_multipacket_reassembler_macros.svh @@
// Assertion macros for the BAM reassembler
`ifndef BAM_MULTIPACKET_REASSEMBLER_MACROS_SVH
`define BAM_MULTIPACKET_REASSEMBLER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BAM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BAM_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BAM_ASSERT(label, clk, rst_n, prop, msg)
`define BAM_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ hdl/bam_pkg.sv @@
// Package: types, codes and constants of the BAM reassembler
`default_nettype none
package bam_pkg;
    localparam int MAX_PACKETS_DEF = 32;
    localparam logic [7:0]  BCAST_ADDR = 8'd255;
    localparam logic [17:0] PGN_CONN   = 18'h0EC00;
    localparam logic [17:0] PGN_DATA   = 18'h0EB00;
    localparam logic [7:0]  CTRL_BAM   = 8'd32;
    localparam logic [2:0]  BYTES_PER_PACKET = 3'd7;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NOT_BCAST  = 2'd1,
        ST_UNEXPECTED = 2'd2,
        ST_INCOMPLETE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_EMIT,
        S_SINGLE
    } state_t;

    typedef struct packed {
        logic [7:0]  dest_address;
        logic [7:0]  source_address;
        logic [17:0] frame_pgn;
        logic [2:0]  frame_priority;
        logic [7:0]  control_type;
        logic [15:0] message_size;
        logic [7:0]  packet_count;
        logic [17:0] carried_pgn;
        logic [7:0]  sequence_number;
        logic [55:0] packet_payload;
    } frame_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        has_chunk;
        logic [2:0]  message_priority;
        logic [17:0] message_pgn;
        logic [7:0]  message_source;
        logic [15:0] message_length;
        logic [55:0] chunk_data;
        logic [2:0]  chunk_bytes;
        logic        last_result;
    } result_t;

    // session record, kept in memory; active bits live in flip-flops
    typedef struct packed {
        logic [2:0]  priority_f;
        logic [17:0] pgn;
        logic [15:0] size;
        logic [7:0]  packets;
        logic [7:0]  last_sq;
    } session_t;

    // chunk step record (remaining bytes, first flag); the sequencer and the trim unit do not use it
    typedef struct packed {
        logic [16:0] remain;
        logic        first;
    } trim_ctl_t;
endpackage
`default_nettype wire

@@ hdl/bam_if.sv @@
// Valid/ready channel interfaces
`default_nettype none
interface bam_frame_if;
    import bam_pkg::*;
    logic   valid;
    logic   ready;
    frame_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bam_result_if;
    import bam_pkg::*;
    logic    valid;
    logic    ready;
    result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/bam_multipacket_reassembler.sv @@
// Top level: BAM transport reassembler with sequencer, session and packet memories
//
// Channels: frames come in on in_ch (valid/ready), results leave on out_ch.
// Each frame gives one result, or, when it completes a message, one chunk
// result per seven-byte chunk (at most MAX_PACKETS), the last with last_result.
// Sequence: a frame is taken in IDLE and passes through LOOKUP and DECIDE;
// a single result is then registered in SINGLE and the block returns to IDLE.
// A completing frame goes from DECIDE to EMIT_RD, which registers the chunk
// count; EMIT_WAIT waits for the registered read of the packet memory and
// EMIT emits one chunk, returning to EMIT_WAIT for each further chunk and
// holding while the receiver stalls. The single read port of the packet
// memory paces the chunk loop. in_ch.ready is high only in IDLE; one frame
// at a time.
// Reset: every session goes inactive (active flags in flip-flops), error
// status goes to ok; the memories are not cleared and need no clearing pass.
// A stalled receiver holds the result register and the sequencer waits.
`default_nettype none
`include "bam_multipacket_reassembler_macros.svh"
module bam_multipacket_reassembler
    import bam_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    bam_frame_if.sink    in_ch,
    bam_result_if.source out_ch
);
    localparam int PW = (MAX_PACKETS > 1) ? $clog2(MAX_PACKETS) : 1;
    localparam int AW = 8 + PW;
    localparam int SW = $bits(session_t);

    state_t   state_reg, state_next;
    frame_t   frame_reg, frame_next;
    status_t  err_reg, err_next;
    logic [255:0] active_reg, active_next;
    logic [7:0]   k_reg, k_next, n_reg, n_next;
    logic [16:0]  remain_reg, remain_next;
    logic         out_valid_reg, out_valid_next;
    result_t      out_reg, out_next;
    session_t     sess_rd, sess_wdata, sess_reg, sess_next;
    logic         sess_we, pkt_we;
    logic [55:0]  pkt_rd;
    logic [AW-1:0] pkt_waddr, pkt_raddr;
    logic [16:0]  trim_rem;
    logic [2:0]   trim_nb;
    logic [55:0]  trim_data;
    logic [16:0]  size_up;
    logic [7:0]   nchunks;

    bam_ram #(.WIDTH(SW), .DEPTH(256)) u_sess (
        .clk(clk), .we(sess_we), .waddr(frame_reg.source_address),
        .wdata(sess_wdata), .raddr(frame_reg.source_address), .rdata(sess_rd)
    );

    bam_ram #(.WIDTH(56), .DEPTH(256 * (1 << PW))) u_pkt (
        .clk(clk), .we(pkt_we), .waddr(pkt_waddr), .wdata(frame_reg.packet_payload),
        .raddr(pkt_raddr), .rdata(pkt_rd)
    );

    bam_trim u_trim (
        .remain(remain_reg), .raw(pkt_rd),
        .remain_next(trim_rem), .nbytes(trim_nb), .data(trim_data)
    );

    assign pkt_waddr = {frame_reg.source_address, PW'(frame_reg.sequence_number - 8'd1)};
    assign pkt_raddr = {frame_reg.source_address, PW'(k_reg)};
    assign in_ch.ready   = (state_reg == S_IDLE);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.payload = out_reg;

    // chunk count: ceil(size/7) by reciprocal, capped at packets, at least one
    always_comb
    begin
        logic [33:0] prod;
        logic [7:0]  q;
        size_up = 17'(sess_reg.size) + 17'd6;
        prod    = 34'(size_up) * 34'd37450;
        q       = 8'((prod >> 18) > 34'd255 ? 34'd255 : (prod >> 18));
        if (17'(q) * 17'd7 > size_up)
        begin
            q = q - 8'd1;
        end
        else if (17'(q) * 17'd7 + 17'd7 <= size_up)
        begin
            q = q + 8'd1;
        end
        if (size_up >= 17'(sess_reg.packets) * 17'd7)
        begin
            q = sess_reg.packets;
        end
        nchunks = (q == 8'd0) ? 8'd1 : q;
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= ST_OK;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        frame_reg  <= frame_next;
        k_reg      <= k_next;
        n_reg      <= n_next;
        remain_reg <= remain_next;
        out_reg    <= out_next;
        sess_reg   <= sess_next;
    end

    // sequencer: decide, then emit a single result or chunks through the trim unit
    always_comb
    begin
        logic act;
        state_next     = state_reg;
        frame_next     = frame_reg;
        err_next       = err_reg;
        active_next    = active_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        remain_next    = remain_reg;
        out_next       = out_reg;
        sess_next      = sess_reg;
        sess_we        = 1'b0;
        sess_wdata     = sess_rd;
        pkt_we         = 1'b0;
        out_valid_next = out_valid_reg;
        act            = active_reg[frame_reg.source_address];
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    frame_next = in_ch.payload;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_SINGLE;
                sess_next  = sess_rd;
                if (frame_reg.dest_address != BCAST_ADDR)
                begin
                    err_next = ST_NOT_BCAST;
                end
                else if (frame_reg.frame_pgn == PGN_CONN)
                begin
                    if (frame_reg.control_type != CTRL_BAM)
                    begin
                        err_next = ST_UNEXPECTED;
                    end
                    else if (frame_reg.packet_count == 8'd0 ||
                             32'(frame_reg.packet_count) > MAX_PACKETS)
                    begin
                        active_next[frame_reg.source_address] = 1'b0;
                        err_next = ST_UNEXPECTED;
                    end
                    else
                    begin
                        err_next = act ? ST_INCOMPLETE : ST_OK;
                        active_next[frame_reg.source_address] = 1'b1;
                        sess_we    = 1'b1;
                        sess_wdata = '{priority_f: frame_reg.frame_priority,
                                       pgn: frame_reg.carried_pgn,
                                       size: frame_reg.message_size,
                                       packets: frame_reg.packet_count,
                                       last_sq: 8'd0};
                    end
                end
                else if (frame_reg.frame_pgn == PGN_DATA)
                begin
                    if (!act || frame_reg.sequence_number > sess_rd.packets ||
                        sess_rd.last_sq + 8'd1 != frame_reg.sequence_number)
                    begin
                        err_next = ST_UNEXPECTED;
                    end
                    else
                    begin
                        pkt_we  = 1'b1;
                        sess_we = 1'b1;
                        sess_wdata.last_sq = frame_reg.sequence_number;
                        if (frame_reg.sequence_number == sess_rd.packets)
                        begin
                            err_next = ST_OK;
                            active_next[frame_reg.source_address] = 1'b0;
                            k_next      = 8'd0;
                            remain_next = 17'(sess_rd.size);
                            state_next  = S_EMIT_RD;
                        end
                    end
                end
                else
                begin
                    err_next = ST_UNEXPECTED;
                end
            end
            S_EMIT_RD:
            begin
                n_next     = nchunks;
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next = '{status: err_reg, has_chunk: 1'b1,
                                 message_priority: sess_reg.priority_f,
                                 message_pgn: sess_reg.pgn,
                                 message_source: frame_reg.source_address,
                                 message_length: sess_reg.size,
                                 chunk_data: trim_data, chunk_bytes: trim_nb,
                                 last_result: (k_reg + 8'd1 == n_reg)};
                    remain_next = trim_rem;
                    k_next      = k_reg + 8'd1;
                    state_next  = (k_reg + 8'd1 == n_reg) ? S_IDLE : S_EMIT_WAIT;
                end
            end
            S_SINGLE:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next.status      = err_reg;
                    out_next.last_result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BAM_ASSERT(a_ready_idle, clk, rst_n, in_ch.ready |-> !(state_reg == S_EMIT), "ready while emitting")
    `BAM_ASSERT(a_chunk_ok, clk, rst_n, (out_ch.valid && out_ch.payload.has_chunk) |-> out_ch.payload.status == ST_OK, "chunk with error status")
    `BAM_ASSERT(a_take_lookup, clk, rst_n, (in_ch.valid && in_ch.ready) |=> state_reg == S_LOOKUP, "accept without lookup")
    `BAM_ASSERT(a_bytes, clk, rst_n, (out_ch.valid && !out_ch.payload.has_chunk) |-> out_ch.payload.chunk_bytes == 3'd0, "bytes without chunk")
endmodule
`default_nettype wire

@@ hdl/bam_ram.sv @@
// Generic single-port-write, registered-read RAM
`default_nettype none
module bam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hdl/bam_trim.sv @@
// Subtract/compare unit: byte count and mask of one chunk
`default_nettype none
module bam_trim
    import bam_pkg::*;
(
    input  wire logic [16:0] remain,
    input  wire logic [55:0] raw,
    output logic      [16:0] remain_next,
    output logic      [2:0]  nbytes,
    output logic      [55:0] data
);
    logic [16:0] diff;

    // one subtract decides full or partial chunk
    always_comb
    begin
        diff = remain - 17'(BYTES_PER_PACKET);
        if (diff[16])
        begin
            nbytes      = remain[2:0];
            remain_next = '0;
        end
        else
        begin
            nbytes      = BYTES_PER_PACKET;
            remain_next = diff;
        end
        for (int b = 0; b < 7; b++)
        begin
            data[b*8 +: 8] = (3'(b) < nbytes) ? raw[b*8 +: 8] : 8'd0;
        end
    end
endmodule
`default_nettype wire

@@ tb/bam_reassembly_checker.sv @@
// Checker: watches the frame and result channels, predicts reassembly, compares
`timescale 1ns / 100ps
`default_nettype none
module bam_reassembly_checker
    import bam_pkg::*;
#(
    parameter int MAX_PACKETS = MAX_PACKETS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    bam_frame_if.sink    in_ch,
    bam_result_if.sink   out_ch,
    output int           fail_count,
    output int           pending_results
);
    typedef struct {
        bit          active;
        logic [2:0]  prio;
        logic [17:0] pgn;
        logic [15:0] size;
        logic [7:0]  packets;
        logic [7:0]  last_sq;
    } bam_session_t;

    bam_session_t sessions [256];
    logic [55:0]  packets_held [256][MAX_PACKETS];
    status_t      sticky_status;
    result_t      expected_results [$];

    // count and print one mismatch
    task automatic report_mismatch(input string what, input result_t got, input result_t want);
        fail_count++;
        $display("%0t: %s: got %h want %h", $time, what, got, want);
    endtask

    function automatic result_t plain_result(input status_t st);
        result_t r;
        r = '0;
        r.status = st;
        r.last_result = 1'b1;
        return r;
    endfunction

    // update the sessions for one frame and queue its results
    task automatic predict_frame(input frame_t f);
        int src;
        int n;
        int off;
        int nb;
        logic [55:0] d;
        result_t r;
        src = f.source_address;
        if (f.dest_address != BCAST_ADDR)
            sticky_status = ST_NOT_BCAST;
        else if (f.frame_pgn == PGN_CONN)
        begin
            if (f.control_type != CTRL_BAM)
                sticky_status = ST_UNEXPECTED;
            else if (f.packet_count == 0 || f.packet_count > MAX_PACKETS)
            begin
                sessions[src].active = 0;
                sticky_status = ST_UNEXPECTED;
            end
            else
            begin
                sticky_status = sessions[src].active ? ST_INCOMPLETE : ST_OK;
                sessions[src].active  = 1;
                sessions[src].prio    = f.frame_priority;
                sessions[src].pgn     = f.carried_pgn;
                sessions[src].size    = f.message_size;
                sessions[src].packets = f.packet_count;
                sessions[src].last_sq = 0;
            end
        end
        else if (f.frame_pgn == PGN_DATA)
        begin
            if (!sessions[src].active || f.sequence_number > sessions[src].packets
                || int'(sessions[src].last_sq) + 1 != int'(f.sequence_number))
                sticky_status = ST_UNEXPECTED;
            else
            begin
                packets_held[src][f.sequence_number - 1] = f.packet_payload;
                sessions[src].last_sq = f.sequence_number;
                if (f.sequence_number == sessions[src].packets)
                begin
                    n = (int'(sessions[src].size) + 6) / 7;
                    if (n > sessions[src].packets)
                        n = sessions[src].packets;
                    if (n == 0)
                        n = 1;
                    sticky_status = ST_OK;
                    sessions[src].active = 0;
                    for (int k = 0; k < n; k++)
                    begin
                        off = k * 7;
                        nb = 7;
                        if (int'(sessions[src].size) < off)
                            nb = 7;
                        else if (int'(sessions[src].size) - off < 7)
                            nb = int'(sessions[src].size) - off;
                        d = packets_held[src][k];
                        if (nb < 7)
                            d &= (56'd1 << (8 * nb)) - 56'd1;
                        r = '0;
                        r.status           = ST_OK;
                        r.has_chunk        = 1'b1;
                        r.message_priority = sessions[src].prio;
                        r.message_pgn      = sessions[src].pgn;
                        r.message_source   = f.source_address;
                        r.message_length   = sessions[src].size;
                        r.chunk_data       = d;
                        r.chunk_bytes      = 3'(nb);
                        r.last_result      = (k + 1 == n);
                        expected_results.push_back(r);
                    end
                    return;
                end
            end
        end
        else
            sticky_status = ST_UNEXPECTED;
        expected_results.push_back(plain_result(sticky_status));
    endtask

    // watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            foreach (sessions[i])
                sessions[i].active = 0;
            sticky_status = ST_OK;
            fail_count = 0;
            expected_results.delete();
            pending_results = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result", got, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                        report_mismatch("result mismatch", got, want);
                end
            end
            if (in_ch.valid && in_ch.ready)
                predict_frame(in_ch.payload);
            pending_results = expected_results.size();
        end
    end
endmodule
`default_nettype wire

@@ tb/bam_multipacket_reassembler_tb.sv @@
// Testbench top: clock, reset, frame stimulus, receiver stalls and verdict
`timescale 1ns / 100ps
`default_nettype none
module bam_multipacket_reassembler_tb;
    import bam_pkg::*;

    localparam int MAXP = MAX_PACKETS_DEF;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_results;
    int   send_idle_pct;
    int   recv_stall_pct;

    bam_frame_if  in_ch ();
    bam_result_if out_ch ();

    bam_multipacket_reassembler #(.MAX_PACKETS(MAXP)) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    bam_reassembly_checker #(.MAX_PACKETS(MAXP)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch.sink),
        .out_ch          (out_ch.sink),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // stall the receiver at random
    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic frame_t random_frame();
        frame_t f;
        f.dest_address    = 8'($urandom);
        f.source_address  = 8'($urandom);
        f.frame_pgn       = 18'($urandom);
        f.frame_priority  = 3'($urandom);
        f.control_type    = 8'($urandom);
        f.message_size    = 16'($urandom);
        f.packet_count    = 8'($urandom);
        f.carried_pgn     = 18'($urandom);
        f.sequence_number = 8'($urandom);
        f.packet_payload  = 56'({$urandom, $urandom});
        return f;
    endfunction

    function automatic frame_t bam_frame(input logic [7:0] src, input logic [15:0] size,
                                         input logic [7:0] count);
        frame_t f;
        f = random_frame();
        f.dest_address = BCAST_ADDR;
        f.source_address = src;
        f.frame_pgn = PGN_CONN;
        f.control_type = CTRL_BAM;
        f.message_size = size;
        f.packet_count = count;
        return f;
    endfunction

    function automatic frame_t data_frame(input logic [7:0] src, input logic [7:0] sq);
        frame_t f;
        f = random_frame();
        f.dest_address = BCAST_ADDR;
        f.source_address = src;
        f.frame_pgn = PGN_DATA;
        f.sequence_number = sq;
        return f;
    endfunction

    // hand one request over, with random idle cycles first
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.payload <= f;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // announce and send a whole message, optionally with a broken sequence
    task automatic send_message(input logic [7:0] src, input logic [15:0] size,
                                input int count, input bit broken);
        send_frame(bam_frame(src, size, 8'(count)));
        for (int k = 1; k <= count; k++)
        begin
            if (broken && $urandom_range(9) == 0)
                send_frame(data_frame(src, 8'($urandom_range(count + 1))));
            send_frame(data_frame(src, 8'(k)));
        end
    endtask

    initial
    begin
        frame_t f;
        int count;
        in_ch.valid = 0;
        in_ch.payload = '0;
        out_ch.ready = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: error kinds, size extremes, restarted session
        f = random_frame(); f.dest_address = 8'd0; send_frame(f);
        f = random_frame(); f.dest_address = BCAST_ADDR; f.frame_pgn = 18'h3FFFF; send_frame(f);
        f = bam_frame(8'd3, 16'd10, 8'd2); f.control_type = 8'd16; send_frame(f);
        send_frame(bam_frame(8'd3, 16'd10, 8'd0));
        send_frame(bam_frame(8'd3, 16'd10, 8'(MAXP + 1)));
        send_frame(data_frame(8'd4, 8'd1));
        send_message(8'd0, 16'd0, 1, 0);
        send_message(8'd255, 16'hFFFF, 3, 0);
        send_message(8'd7, 16'd13, 2, 0);
        send_frame(bam_frame(8'd9, 16'd20, 8'd3));
        send_frame(data_frame(8'd9, 8'd1));
        send_frame(data_frame(8'd9, 8'd3));
        send_frame(data_frame(8'd9, 8'd0));
        send_message(8'd9, 16'(7 * MAXP), MAXP, 0);

        // random: mostly whole messages across sender-idle and receiver-stall phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? 61 : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? 61 : 0;
            if (ph == 3)
            begin
                send_idle_pct = 8;
                recv_stall_pct = 8;
            end
            for (int i = 0; i < 20; i++)
            begin
                count = ($urandom_range(9) == 0) ? $urandom_range(MAXP) + 1
                                                  : $urandom_range(4) + 1;
                if ($urandom_range(4) == 0)
                    send_frame(random_frame());
                send_message(8'($urandom_range(3) * 85), 16'($urandom_range(count * 7 + 3)),
                             count > MAXP ? MAXP : count, $urandom_range(3) == 0);
            end
        end
        in_ch.valid <= 1'b0;

        while (pending_results != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/bam_pkg.sv
hdl/bam_if.sv
hdl/bam_ram.sv
hdl/bam_trim.sv
hdl/bam_multipacket_reassembler.sv
tb/bam_reassembly_checker.sv
tb/bam_multipacket_reassembler_tb.sv
